// File: hw/rtl/minv4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv4_pkg
// Types, widths and index helpers shared by the 4x4 matrix inverse core.
// ----------------------------------------------------------------------------
package minv4_pkg;

	localparam int ELEM_W  = 32;
	localparam int ROWS    = 4;
	localparam int ROW_W   = ELEM_W * ROWS;
	// |cofactor| < 6 * 2^93, so 97 bits signed hold it exactly
	localparam int COF_W   = 97;
	// |det| < 4 * 2^31 * 2^96
	localparam int DET_W   = 132;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int TUSER_W = 4;
	localparam int Q_DEPTH = 4;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef logic [1:0] row_idx_t;

	localparam row_idx_t   LAST_ROW      = 2'd3;
	localparam logic [2:0] LAST_TERM     = 3'd5;
	localparam logic [2:0] COF_LAST_STEP = 3'd6;
	localparam logic [2:0] DET_LAST_STEP = 3'd5;

	typedef struct packed {
		row_idx_t             row;
		logic [ROW_W-1:0]     data;
	} row_beat_t;

	typedef enum logic [2:0] {
		BK_LOAD,
		BK_COF,
		BK_DET,
		BK_CHK,
		BK_SING,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} div_state_t;

	// i-th index of {0..3} with x removed
	function automatic row_idx_t skip_idx(input row_idx_t x, input logic [1:0] i);
		return (i >= x) ? row_idx_t'(i + 2'd1) : i;
	endfunction

	// column permutation k of a 3x3 minor, element i
	function automatic logic [1:0] perm_sel(input logic [2:0] k, input logic [1:0] i);
		logic [5:0] p;
		unique case (k)
			3'd0: p = {2'd2, 2'd1, 2'd0};
			3'd1: p = {2'd1, 2'd2, 2'd0};
			3'd2: p = {2'd2, 2'd0, 2'd1};
			3'd3: p = {2'd0, 2'd2, 2'd1};
			3'd4: p = {2'd1, 2'd0, 2'd2};
			3'd5: p = {2'd0, 2'd1, 2'd2};
			default: p = {2'd2, 2'd1, 2'd0};
		endcase
		return p[i*2 +: 2];
	endfunction

	function automatic logic perm_odd(input logic [2:0] k);
		return (k == 3'd1) || (k == 3'd2) || (k == 3'd5);
	endfunction

	function automatic logic signed [ELEM_W-1:0] col_of(input logic [ROW_W-1:0] row,
		input logic [1:0] c);
		return row[c*ELEM_W +: ELEM_W];
	endfunction

endpackage

// File: hw/rtl/minv4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv4_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module minv4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd <= mem_q[ra];
	end

endmodule

// File: hw/rtl/minv4_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv4_front
// Accepts row beats, tags each with its row number and queues it for the
// compute engine.
// ----------------------------------------------------------------------------
module minv4_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [minv4_pkg::ROW_W-1:0] s_tdata,
	output logic                    q_valid,
	input  logic                    q_ready,
	output minv4_pkg::row_beat_t    q_beat
);

	minv4_pkg::row_beat_t            fifo_q [minv4_pkg::Q_DEPTH];
	minv4_pkg::row_idx_t             rows_q;
	logic [minv4_pkg::PTR_W-1:0]     wr_ptr_q;
	logic [minv4_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [minv4_pkg::QCNT_W-1:0]    count_q;
	logic                            push;
	logic                            pop;

	assign s_tready = (count_q != minv4_pkg::QCNT_W'(minv4_pkg::Q_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_beat   = fifo_q[rd_ptr_q];
	assign push     = s_tvalid & s_tready;
	assign pop      = q_valid & q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				rows_q   <= rows_q + 2'd1;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{row: rows_q, data: s_tdata};
		end
	end

endmodule

// File: hw/rtl/minv4_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv4_div
// Restoring divider: |cof| * 2^(2*FRAC_BITS) / |det|, one quotient bit per
// cycle, truncated toward zero and saturated to 32 bits signed.
// ----------------------------------------------------------------------------
module minv4_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [minv4_pkg::COF_W-1:0]   num,
	input  logic signed [minv4_pkg::DET_W-1:0]   den,
	output logic                                 done,
	output logic [minv4_pkg::ELEM_W-1:0]         quo,
	output logic                                 sat
);

	localparam int NUM_W  = minv4_pkg::COF_W + 2 * FRAC_BITS;
	localparam int DSH_W  = minv4_pkg::DET_W + minv4_pkg::ELEM_W;
	localparam int CMP_W  = (DSH_W > NUM_W) ? DSH_W : NUM_W;
	localparam int QB     = minv4_pkg::ELEM_W + 1;
	localparam int CNT_W  = $clog2(QB);

	minv4_pkg::div_state_t            st_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [NUM_W-1:0]                 r_q;
	logic [DSH_W-1:0]                 d_q;
	logic [QB-1:0]                    q_q;
	logic                             neg_q;
	logic [minv4_pkg::COF_W-1:0]      num_mag;
	logic [minv4_pkg::DET_W-1:0]      den_mag;
	logic [CMP_W-1:0]                 r_ext;
	logic [CMP_W-1:0]                 d_ext;
	logic [CMP_W-1:0]                 diff;
	logic                             ge;
	logic [minv4_pkg::ELEM_W-1:0]     limit;

	assign num_mag = num[minv4_pkg::COF_W-1] ? minv4_pkg::COF_W'(-num) : minv4_pkg::COF_W'(num);
	assign den_mag = den[minv4_pkg::DET_W-1] ? minv4_pkg::DET_W'(-den) : minv4_pkg::DET_W'(den);
	assign r_ext   = CMP_W'(r_q);
	assign d_ext   = CMP_W'(d_q);
	assign ge      = (r_ext >= d_ext);
	assign diff    = r_ext - d_ext;

	// limit is also the saturated value for the sign
	assign limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign done  = (st_q == minv4_pkg::DV_DONE);
	assign sat   = q_q[QB-1] | (q_q[minv4_pkg::ELEM_W-1:0] > limit);
	assign quo   = sat ? limit :
		(neg_q ? (-q_q[minv4_pkg::ELEM_W-1:0]) : q_q[minv4_pkg::ELEM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= minv4_pkg::DV_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				minv4_pkg::DV_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						st_q <= minv4_pkg::DV_RUN;
					end
				end
				minv4_pkg::DV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QB - 1)) begin
						st_q <= minv4_pkg::DV_DONE;
					end
				end
				minv4_pkg::DV_DONE: st_q <= minv4_pkg::DV_IDLE;
				default:            st_q <= minv4_pkg::DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == minv4_pkg::DV_IDLE && start) begin
			r_q   <= NUM_W'(num_mag) << (2 * FRAC_BITS);
			d_q   <= DSH_W'(den_mag) << minv4_pkg::ELEM_W;
			q_q   <= '0;
			neg_q <= num[minv4_pkg::COF_W-1] ^ den[minv4_pkg::DET_W-1];
		end else if (st_q == minv4_pkg::DV_RUN) begin
			if (ge) begin
				r_q <= NUM_W'(diff);
			end
			q_q <= {q_q[QB-2:0], ge};
			d_q <= d_q >> 1;
		end
	end

endmodule

// File: hw/rtl/minv4_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minv4_back
// Compute engine: loads queued rows, forms cofactors and determinant on one
// shared 33x33 multiplier, divides cofactors, emits inverse or singular rows.
// ----------------------------------------------------------------------------
module minv4_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  minv4_pkg::row_beat_t              q_beat,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [minv4_pkg::ROW_W-1:0]       m_tdata,
	output logic [minv4_pkg::TUSER_W-1:0]     m_tuser,
	output logic                              m_tlast
);

	localparam int EW = minv4_pkg::ELEM_W;

	minv4_pkg::back_state_t                   state_q;
	minv4_pkg::back_state_t                   state_nxt;
	logic [3:0]                               idx_q;
	logic [2:0]                               term_q;
	logic [2:0]                               step_q;
	minv4_pkg::row_idx_t                      r_cur;
	minv4_pkg::row_idx_t                      c_cur;
	logic                                     cof_sign;

	logic signed [EW-1:0]                     x_q;
	logic signed [2*EW-1:0]                   p_q;
	logic signed [minv4_pkg::PROD_W-1:0]      t_q;
	logic [minv4_pkg::COF_W-1:0]              cw_q;
	logic signed [minv4_pkg::DET_W-1:0]       acc_q;
	logic signed [minv4_pkg::DET_W-1:0]       det_q;
	logic [EW-1:0]                            row_q [minv4_pkg::ROWS];
	logic                                     rovf_q;

	logic                                     out_valid_q;
	logic [minv4_pkg::ROW_W-1:0]              out_data_q;
	logic [minv4_pkg::TUSER_W-1:0]            out_user_q;
	logic                                     out_last_q;
	logic                                     slot_free;
	logic                                     out_load;

	logic signed [minv4_pkg::MUL_W-1:0]       mul_a;
	logic signed [minv4_pkg::MUL_W-1:0]       mul_b;
	logic signed [minv4_pkg::PROD_W-1:0]      mul_p;
	logic [1:0]                               acc_sh;
	logic                                     acc_neg;
	logic signed [minv4_pkg::DET_W-1:0]       add_ext;
	logic signed [minv4_pkg::DET_W-1:0]       add_sh;
	logic signed [minv4_pkg::DET_W-1:0]       acc_add;

	logic                                     mat_we;
	minv4_pkg::row_idx_t                      mat_ra;
	logic [minv4_pkg::ROW_W-1:0]              mat_rd;
	logic                                     cof_we;
	logic [3:0]                               cof_ra;
	logic [minv4_pkg::COF_W-1:0]              cof_rd;

	logic                                     div_start;
	logic                                     div_done;
	logic [EW-1:0]                            div_val;
	logic                                     div_sat;

	assign r_cur    = idx_q[3:2];
	assign c_cur    = idx_q[1:0];
	assign cof_sign = minv4_pkg::perm_odd(term_q) ^ r_cur[0] ^ c_cur[0];
	assign q_ready  = (state_q == minv4_pkg::BK_LOAD);
	assign mat_we   = q_valid & q_ready;
	assign slot_free = !out_valid_q || m_tready;

	assign mul_p   = mul_a * mul_b;
	assign add_ext = minv4_pkg::DET_W'(t_q);

	always_comb begin
		unique case (acc_sh)
			2'd1:    add_sh = add_ext <<< 32;
			2'd2:    add_sh = add_ext <<< 64;
			default: add_sh = add_ext;
		endcase
		acc_add = acc_neg ? (acc_q - add_sh) : (acc_q + add_sh);
	end

	assign cof_we = (state_q == minv4_pkg::BK_COF) && (step_q == minv4_pkg::COF_LAST_STEP)
		&& (term_q == minv4_pkg::LAST_TERM);

	always_comb begin
		state_nxt = state_q;
		mat_ra    = '0;
		cof_ra    = '0;
		mul_a     = '0;
		mul_b     = '0;
		acc_sh    = 2'd0;
		acc_neg   = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			minv4_pkg::BK_LOAD: begin
				if (q_valid && q_beat.row == minv4_pkg::LAST_ROW) begin
					state_nxt = minv4_pkg::BK_COF;
				end
			end
			minv4_pkg::BK_COF: begin
				acc_neg = cof_sign;
				unique case (step_q)
					3'd0: mat_ra = minv4_pkg::skip_idx(r_cur, 2'd0);
					3'd1: mat_ra = minv4_pkg::skip_idx(r_cur, 2'd1);
					3'd2: begin
						mat_ra = minv4_pkg::skip_idx(r_cur, 2'd2);
						mul_a  = minv4_pkg::MUL_W'(x_q);
						mul_b  = minv4_pkg::MUL_W'(minv4_pkg::col_of(mat_rd,
							minv4_pkg::skip_idx(c_cur, minv4_pkg::perm_sel(term_q, 2'd1))));
					end
					3'd4: begin
						mul_a = $signed({1'b0, p_q[EW-1:0]});
						mul_b = minv4_pkg::MUL_W'(x_q);
					end
					3'd5: begin
						mul_a = minv4_pkg::MUL_W'($signed(p_q[2*EW-1:EW]));
						mul_b = minv4_pkg::MUL_W'(x_q);
					end
					3'd6: begin
						acc_sh = 2'd1;
						if (term_q == minv4_pkg::LAST_TERM && idx_q == 4'hF) begin
							state_nxt = minv4_pkg::BK_DET;
						end
					end
					default: ;
				endcase
			end
			minv4_pkg::BK_DET: begin
				cof_ra = {2'b00, c_cur};
				unique case (step_q)
					3'd2: begin
						mul_a = $signed({1'b0, cw_q[EW-1:0]});
						mul_b = minv4_pkg::MUL_W'(x_q);
					end
					3'd3: begin
						mul_a = $signed({1'b0, cw_q[2*EW-1:EW]});
						mul_b = minv4_pkg::MUL_W'(x_q);
					end
					3'd4: begin
						acc_sh = 2'd1;
						mul_a  = $signed(cw_q[minv4_pkg::COF_W-1:2*EW]);
						mul_b  = minv4_pkg::MUL_W'(x_q);
					end
					3'd5: begin
						acc_sh = 2'd2;
						if (c_cur == minv4_pkg::LAST_ROW) begin
							state_nxt = minv4_pkg::BK_CHK;
						end
					end
					default: ;
				endcase
			end
			minv4_pkg::BK_CHK: begin
				state_nxt = (det_q == '0) ? minv4_pkg::BK_SING : minv4_pkg::BK_DIV;
			end
			minv4_pkg::BK_SING: begin
				if (slot_free) begin
					out_load  = 1'b1;
					state_nxt = minv4_pkg::BK_LOAD;
				end
			end
			minv4_pkg::BK_DIV: begin
				// inverse element (k,c) takes cofactor (c,k)
				cof_ra    = {c_cur, r_cur};
				div_start = (step_q == 3'd1);
				if (step_q == 3'd2 && div_done && c_cur == minv4_pkg::LAST_ROW) begin
					state_nxt = minv4_pkg::BK_EMIT;
				end
			end
			minv4_pkg::BK_EMIT: begin
				if (slot_free) begin
					out_load  = 1'b1;
					state_nxt = (r_cur == minv4_pkg::LAST_ROW) ? minv4_pkg::BK_LOAD
						: minv4_pkg::BK_DIV;
				end
			end
			default: state_nxt = minv4_pkg::BK_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= minv4_pkg::BK_LOAD;
			idx_q       <= '0;
			term_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				minv4_pkg::BK_LOAD: begin
					idx_q  <= '0;
					term_q <= '0;
					step_q <= '0;
				end
				minv4_pkg::BK_COF: begin
					if (step_q == minv4_pkg::COF_LAST_STEP) begin
						step_q <= '0;
						if (term_q == minv4_pkg::LAST_TERM) begin
							term_q <= '0;
							idx_q  <= idx_q + 4'd1;
						end else begin
							term_q <= term_q + 3'd1;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				minv4_pkg::BK_DET: begin
					if (step_q == minv4_pkg::DET_LAST_STEP) begin
						step_q <= '0;
						idx_q  <= (c_cur == minv4_pkg::LAST_ROW) ? 4'd0 : idx_q + 4'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				minv4_pkg::BK_CHK: begin
					idx_q  <= '0;
					step_q <= '0;
				end
				minv4_pkg::BK_DIV: begin
					if (step_q != 3'd2) begin
						step_q <= step_q + 3'd1;
					end else if (div_done) begin
						step_q <= '0;
						if (c_cur != minv4_pkg::LAST_ROW) begin
							idx_q <= idx_q + 4'd1;
						end
					end
				end
				minv4_pkg::BK_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		t_q <= mul_p;
		unique case (state_q)
			minv4_pkg::BK_LOAD: acc_q <= '0;
			minv4_pkg::BK_COF: begin
				unique case (step_q)
					3'd1: x_q <= minv4_pkg::col_of(mat_rd,
						minv4_pkg::skip_idx(c_cur, minv4_pkg::perm_sel(term_q, 2'd0)));
					3'd3: begin
						p_q <= t_q[2*EW-1:0];
						x_q <= minv4_pkg::col_of(mat_rd,
							minv4_pkg::skip_idx(c_cur, minv4_pkg::perm_sel(term_q, 2'd2)));
					end
					3'd5: acc_q <= acc_add;
					3'd6: acc_q <= (term_q == minv4_pkg::LAST_TERM) ? '0 : acc_add;
					default: ;
				endcase
			end
			minv4_pkg::BK_DET: begin
				unique case (step_q)
					3'd1: begin
						x_q  <= minv4_pkg::col_of(mat_rd, c_cur);
						cw_q <= cof_rd;
					end
					3'd3, 3'd4: acc_q <= acc_add;
					3'd5: begin
						acc_q <= acc_add;
						if (c_cur == minv4_pkg::LAST_ROW) begin
							det_q <= acc_add;
						end
					end
					default: ;
				endcase
			end
			minv4_pkg::BK_CHK: rovf_q <= 1'b0;
			minv4_pkg::BK_DIV: begin
				if (step_q == 3'd2 && div_done) begin
					row_q[c_cur] <= div_val;
					rovf_q       <= rovf_q | div_sat;
				end
			end
			minv4_pkg::BK_EMIT: begin
				if (slot_free) begin
					rovf_q <= 1'b0;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			if (state_q == minv4_pkg::BK_SING) begin
				out_data_q <= '0;
				out_user_q <= {1'b0, 1'b1, 2'd0};
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= {row_q[3], row_q[2], row_q[1], row_q[0]};
				out_user_q <= {rovf_q, 1'b0, r_cur};
				out_last_q <= (r_cur == minv4_pkg::LAST_ROW);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	minv4_ram #(
		.WIDTH (minv4_pkg::ROW_W),
		.DEPTH (minv4_pkg::ROWS)
	) u_mat_ram (
		.clk (clk),
		.we  (mat_we),
		.wa  (q_beat.row),
		.wd  (q_beat.data),
		.ra  (mat_ra),
		.rd  (mat_rd)
	);

	minv4_ram #(
		.WIDTH (minv4_pkg::COF_W),
		.DEPTH (16)
	) u_cof_ram (
		.clk (clk),
		.we  (cof_we),
		.wa  (idx_q),
		.wd  (acc_add[minv4_pkg::COF_W-1:0]),
		.ra  (cof_ra),
		.rd  (cof_rd)
	);

	minv4_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ($signed(cof_rd)),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_val),
		.sat    (div_sat)
	);

endmodule

// File: hw/rtl/matrix_inverse_4x4_core.sv
`timescale 1ns / 1ps
// Sequence: after the fourth row beat the engine forms the sixteen cofactors,
// then the determinant, then divides each element in the bit-serial divider
// and emits inverse rows; a singular matrix answers once the determinant is zero.
// Pace is set by the shared 33x33 multiplier and the one-bit-per-cycle divider;
// meanwhile the queue holds up to four row beats of the next matrix.
// Reset: arst_n clears the row counter, queue, sequencers and output valid.
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_core
// 4x4 Q16.16 matrix inverse by cofactors and adjugate, streaming in and out.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// elem_0, elem_1, elem_2, elem_3
	input  logic [minv4_pkg::ROW_W-1:0]       s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_elem_0, out_elem_1, out_elem_2, out_elem_3
	output logic [minv4_pkg::ROW_W-1:0]       m_tdata,
	// row_index[1:0], singular, overflow
	output logic [minv4_pkg::TUSER_W-1:0]     m_tuser,
	output logic                              m_tlast
);

	logic                    q_valid;
	logic                    q_ready;
	minv4_pkg::row_beat_t    q_beat;

	minv4_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_beat   (q_beat)
	);

	minv4_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_beat   (q_beat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// singular beat is a lone, zeroed, final beat
	a_singular_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast && m_tdata == '0 && m_tuser[1:0] == 2'd0)
		else $error("singular beat malformed");

	a_sing_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[2] && m_tuser[3]))
		else $error("singular and overflow both set");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[2] || m_tuser[1:0] == minv4_pkg::LAST_ROW)
		else $error("last flag on a middle row");

	// hold a stalled beat unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output beat changed");

endmodule
